FILE: design/keypad_matrix_mode_decoder_defines.svh
// Assertion macros for the keypad matrix decoder.
// Taken in by the top level with `include; no other dependencies.
`ifndef KEYPAD_MATRIX_MODE_DECODER_DEFINES_SVH
`define KEYPAD_MATRIX_MODE_DECODER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KMD_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("keypad decoder: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define KMD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("keypad decoder: next-cycle check failed");

`endif

FILE: design/kmd_pkg.sv
// Shared types, codes and the character table of the keypad matrix decoder.
// No dependencies; used by the interfaces and every module.
`timescale 1ns / 1ps

package kmd_pkg;

  localparam int LAYERS   = 5;
  localparam int KEYS     = 16;
  localparam int CASE_GAP = 32;

  typedef logic [KEYS-1:0] matrix_t;
  typedef logic [3:0]      key_idx_t;
  typedef logic [6:0]      code_t;
  typedef logic [2:0]      layer_t;

  // Special result codes
  localparam code_t CODE_NONE  = 7'd0;
  localparam code_t CODE_UNDO  = 7'd1;
  localparam code_t CODE_OK    = 7'd2;
  localparam code_t CODE_CAPS  = 7'd3;
  localparam code_t CODE_MODE  = 7'd4;
  localparam code_t CODE_UP    = 7'd5;
  localparam code_t CODE_DOWN  = 7'd6;
  localparam code_t CODE_LEFT  = 7'd7;
  localparam code_t CODE_RIGHT = 7'd8;

  // Fixed keys in the fourth column
  localparam key_idx_t KEY_OK   = 4'd3;
  localparam key_idx_t KEY_UNDO = 4'd7;
  localparam key_idx_t KEY_CAPS = 4'd11;
  localparam key_idx_t KEY_MODE = 4'd15;

  localparam layer_t LAYER_ARROW = 3'(LAYERS - 1);
  localparam logic [1:0] COL_FIXED = 2'd3;

  localparam code_t CHAR_LC_A = 7'h61;
  localparam code_t CHAR_LC_Z = 7'h7a;

  localparam code_t GLYPHS [LAYERS][KEYS] = '{
    '{7'h31, 7'h32, 7'h33, CODE_OK, 7'h34, 7'h35, 7'h36, CODE_UNDO,
      7'h37, 7'h38, 7'h39, CODE_CAPS, 7'h28, 7'h30, 7'h29, CODE_MODE},
    '{7'h61, 7'h62, 7'h63, CODE_OK, 7'h64, 7'h65, 7'h66, CODE_UNDO,
      7'h67, 7'h68, 7'h69, CODE_CAPS, 7'h6a, 7'h6b, 7'h6c, CODE_MODE},
    '{7'h6d, 7'h6e, 7'h6f, CODE_OK, 7'h70, 7'h71, 7'h72, CODE_UNDO,
      7'h73, 7'h74, 7'h75, CODE_CAPS, 7'h76, 7'h77, 7'h78, CODE_MODE},
    '{7'h79, 7'h7a, 7'h2b, CODE_OK, 7'h7c, 7'h26, 7'h2d, CODE_UNDO,
      7'h25, 7'h3d, 7'h2a, CODE_CAPS, 7'h20, 7'h2e, 7'h2f, CODE_MODE},
    '{CODE_UP, CODE_UP, CODE_UP, CODE_OK, CODE_DOWN, CODE_DOWN, CODE_DOWN, CODE_UNDO,
      CODE_LEFT, CODE_LEFT, CODE_LEFT, CODE_CAPS,
      CODE_RIGHT, CODE_RIGHT, CODE_RIGHT, CODE_MODE}
  };

  // Priority encoder result
  typedef struct packed {
    logic     hit;
    key_idx_t idx;
  } key_sel_t;

  // Decoder result: code plus the state after this item
  typedef struct packed {
    code_t  code;
    layer_t layer;
    logic   caps;
  } dec_res_t;

endpackage

FILE: design/kmd_ifs.sv
// Valid/ready channel interfaces for the keypad matrix decoder.
// Depends on kmd_pkg for the payload types.
`timescale 1ns / 1ps

interface kmd_in_if;
  import kmd_pkg::*;
  logic    valid;
  logic    ready;
  matrix_t key_matrix;
  modport source (output valid, output key_matrix, input ready);
  modport sink   (input valid, input key_matrix, output ready);
endinterface

interface kmd_out_if;
  import kmd_pkg::*;
  logic   valid;
  logic   ready;
  code_t  key_code;
  layer_t layer_now;
  logic   caps_on;
  modport source (output valid, output key_code, output layer_now, output caps_on,
                  input ready);
  modport sink   (input valid, input key_code, input layer_now, input caps_on,
                  output ready);
endinterface

FILE: design/kmd_prio_enc.sv
// Lowest-set-bit priority encoder over the key snapshot.
// Depends on kmd_pkg.
`timescale 1ns / 1ps

module kmd_prio_enc (
  input  kmd_pkg::matrix_t  matrix,
  output kmd_pkg::key_sel_t sel
);
  import kmd_pkg::*;

  always_comb begin
    sel = '0;
    // scan from the top so the lowest set bit wins
    for (int k = KEYS - 1; k >= 0; k--) begin
      if (matrix[k]) begin
        sel.hit = 1'b1;
        sel.idx = key_idx_t'(k);
      end
    end
  end

endmodule

FILE: design/kmd_decode.sv
// Key decode: picks the key, looks up its code and works out the next state.
// Depends on kmd_pkg and kmd_prio_enc.
`timescale 1ns / 1ps

module kmd_decode (
  input  kmd_pkg::matrix_t  matrix,
  input  kmd_pkg::layer_t   layer,
  input  logic              caps,
  output kmd_pkg::dec_res_t res
);
  import kmd_pkg::*;

  key_sel_t sel;
  layer_t   lay;
  code_t    glyph;

  kmd_prio_enc u_prio (
    .matrix (matrix),
    .sel    (sel)
  );

  // out-of-range layer looks up as layer 0
  assign lay   = (layer < layer_t'(LAYERS)) ? layer : '0;
  assign glyph = GLYPHS[lay][sel.idx];

  always_comb begin
    res.code  = CODE_NONE;
    res.layer = layer;
    res.caps  = caps;
    if (sel.hit) begin
      if (lay == LAYER_ARROW && sel.idx[1:0] != COL_FIXED) begin
        res.code = CODE_UP + code_t'(sel.idx[3:2]);
      end else if (sel.idx == KEY_OK) begin
        res.code = CODE_OK;
      end else if (sel.idx == KEY_UNDO) begin
        res.code = CODE_UNDO;
      end else if (sel.idx == KEY_MODE) begin
        res.layer = (lay == LAYER_ARROW) ? '0 : lay + 3'd1;
        res.code  = CODE_MODE;
      end else if (sel.idx == KEY_CAPS) begin
        res.caps = ~caps;
        res.code = CODE_CAPS;
      end else begin
        res.code = glyph;
        if (caps && glyph >= CHAR_LC_A && glyph <= CHAR_LC_Z) begin
          res.code = glyph - code_t'(CASE_GAP);
        end
      end
    end
  end

endmodule

FILE: design/keypad_matrix_mode_decoder.sv
// Keypad matrix decoder, top level: input register, decode, result register.
// Items pass the input register, then the result register; 1 item/cycle unless out_ch.ready stalls.
// The layer and caps state update as an item moves into the result register,
// so the next item is decoded against the updated state with no bubble.
// Synchronous active-low reset clears valids, layer (0) and caps lock (off).
// Depends on kmd_pkg, kmd_ifs, kmd_decode and the assertion macro header.
`timescale 1ns / 1ps
`include "keypad_matrix_mode_decoder_defines.svh"

module keypad_matrix_mode_decoder (
  input  logic       clk,
  input  logic       rst_n,
  kmd_in_if.sink     in_ch,
  kmd_out_if.source  out_ch
);
  import kmd_pkg::*;

  logic     s1_valid_r;
  matrix_t  s1_matrix_r;
  logic     out_valid_r;
  code_t    out_code_r;
  layer_t   out_layer_r;
  logic     out_caps_r;
  layer_t   layer_r;
  logic     caps_r;

  logic     out_free;
  logic     s1_move;
  logic     in_take;
  dec_res_t dec;

  assign out_free = !out_valid_r || out_ch.ready;
  assign s1_move  = s1_valid_r && out_free;
  assign in_ch.ready = !s1_valid_r || out_free;
  assign in_take  = in_ch.valid && in_ch.ready;

  kmd_decode u_decode (
    .matrix (s1_matrix_r),
    .layer  (layer_r),
    .caps   (caps_r),
    .res    (dec)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      layer_r     <= '0;
      caps_r      <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (out_free) begin
        out_valid_r <= s1_valid_r;
      end
      if (s1_move) begin
        layer_r <= dec.layer;
        caps_r  <= dec.caps;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_matrix_r <= in_ch.key_matrix;
    end
    if (s1_move) begin
      out_code_r  <= dec.code;
      out_layer_r <= dec.layer;
      out_caps_r  <= dec.caps;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.key_code  = out_code_r;
  assign out_ch.layer_now = out_layer_r;
  assign out_ch.caps_on   = out_caps_r;

  `KMD_ASSERT_NOW(a_layer_range, clk, rst_n, 1'b1, layer_r < layer_t'(LAYERS))
  `KMD_ASSERT_NOW(a_out_matches_state, clk, rst_n, out_valid_r,
                  out_layer_r == layer_r && out_caps_r == caps_r)
  `KMD_ASSERT_NEXT(a_state_holds_on_stall, clk, rst_n, out_valid_r && !out_ch.ready,
                   $stable(layer_r) && $stable(caps_r))

endmodule

FILE: verif/keypad_matrix_mode_decoder_test.sv
// Self-checking bench for keypad_matrix_mode_decoder: directed table, then random key snapshots.
// Uses its own decode predictor and an in-order queue of expected results.
// Depends on kmd_pkg, kmd_ifs and the decoder RTL.
`timescale 1ns / 1ps

module keypad_matrix_mode_decoder_test;
  import kmd_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int ITEMS_PER_PHASE = 250;
  localparam int HOLD_CYCLES = 80;
  localparam int DRAIN_CYCLES = 10;

  // Character keys of layers 0 to 3; the fourth column is handled as fixed keys
  localparam byte KEY_CHARS [4][16] = '{
    '{"1", "2", "3", 0, "4", "5", "6", 0, "7", "8", "9", 0, "(", "0", ")", 0},
    '{"a", "b", "c", 0, "d", "e", "f", 0, "g", "h", "i", 0, "j", "k", "l", 0},
    '{"m", "n", "o", 0, "p", "q", "r", 0, "s", "t", "u", 0, "v", "w", "x", 0},
    '{"y", "z", "+", 0, "|", "&", "-", 0, "%", "=", "*", 0, " ", ".", "/", 0}
  };

  typedef struct packed {
    matrix_t  keys;
    bit       typed;
    dec_res_t res;
  } key_row_t;

  localparam key_row_t KEY_ROWS [25] = '{
    '{16'h0000, 1'b1, '{CODE_NONE,  3'd0, 1'b0}},  // nothing pressed straight after reset
    '{16'hFFFF, 1'b1, '{7'h31,      3'd0, 1'b0}},  // everything pressed: first key wins
    '{16'h8000, 1'b1, '{CODE_MODE,  3'd1, 1'b0}},
    '{16'h0001, 1'b0, '0},
    '{16'h0800, 1'b1, '{CODE_CAPS,  3'd1, 1'b1}},
    '{16'h0002, 1'b0, '0},                         // upper-case letter
    '{16'h0008, 1'b1, '{CODE_OK,    3'd1, 1'b1}},
    '{16'h0080, 1'b1, '{CODE_UNDO,  3'd1, 1'b1}},
    '{16'h8000, 1'b1, '{CODE_MODE,  3'd2, 1'b1}},
    '{16'h4000, 1'b0, '0},
    '{16'h8000, 1'b1, '{CODE_MODE,  3'd3, 1'b1}},
    '{16'h0002, 1'b0, '0},
    '{16'h0004, 1'b0, '0},                         // symbol, caps has no effect
    '{16'h0800, 1'b1, '{CODE_CAPS,  3'd3, 1'b0}},
    '{16'h0001, 1'b0, '0},
    '{16'h8000, 1'b1, '{CODE_MODE,  3'd4, 1'b0}},
    '{16'h0001, 1'b1, '{CODE_UP,    3'd4, 1'b0}},
    '{16'h0020, 1'b1, '{CODE_DOWN,  3'd4, 1'b0}},
    '{16'h0400, 1'b1, '{CODE_LEFT,  3'd4, 1'b0}},
    '{16'h0800, 1'b1, '{CODE_CAPS,  3'd4, 1'b1}},
    '{16'h2000, 1'b1, '{CODE_RIGHT, 3'd4, 1'b1}},  // arrows ignore caps lock
    '{16'h0000, 1'b1, '{CODE_NONE,  3'd4, 1'b1}},  // no key leaves state alone
    '{16'h8000, 1'b1, '{CODE_MODE,  3'd0, 1'b1}},  // layer wraps to 0
    '{16'hFFFE, 1'b0, '0},
    '{16'h8800, 1'b1, '{CODE_CAPS,  3'd0, 1'b0}}   // lowest set bit decides
  };

  logic clk;
  logic rst_n;

  kmd_in_if  in_ch ();
  kmd_out_if out_ch ();

  keypad_matrix_mode_decoder uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  layer_t   tracked_layer;
  logic     tracked_caps;
  dec_res_t pending_codes [$];
  int       mismatch_count;
  int       cycle_count;
  int       phase;
  int       send_idle_pct;
  int       recv_idle_pct;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic dec_res_t predict_keypress(input matrix_t keys);
    key_idx_t idx;
    logic     found;
    layer_t   lay;
    code_t    code;
    found = 1'b0;
    idx   = '0;
    for (int k = KEYS - 1; k >= 0; k--) begin
      if (keys[k]) begin
        found = 1'b1;
        idx   = key_idx_t'(k);
      end
    end
    lay  = (tracked_layer < LAYERS) ? tracked_layer : layer_t'(0);
    code = CODE_NONE;
    if (found) begin
      if (lay == LAYER_ARROW && idx[1:0] != COL_FIXED) begin
        code = CODE_UP + code_t'(idx[3:2]);
      end else if (idx == KEY_OK) begin
        code = CODE_OK;
      end else if (idx == KEY_UNDO) begin
        code = CODE_UNDO;
      end else if (idx == KEY_MODE) begin
        tracked_layer = (lay == LAYER_ARROW) ? layer_t'(0) : lay + 3'd1;
        code = CODE_MODE;
      end else if (idx == KEY_CAPS) begin
        tracked_caps = ~tracked_caps;
        code = CODE_CAPS;
      end else begin
        code = code_t'(KEY_CHARS[lay[1:0]][idx]);
        if (tracked_caps && code >= CHAR_LC_A && code <= CHAR_LC_Z)
          code = code - code_t'(CASE_GAP);
      end
    end
    return '{code, tracked_layer, tracked_caps};
  endfunction

  function automatic matrix_t random_keys();
    int      pick;
    int      k;
    matrix_t keys;
    pick = $urandom_range(0, 99);
    k    = $urandom_range(0, KEYS - 1);
    if (pick < 8) begin
      keys = '0;
    end else if (pick < 23) begin
      keys = matrix_t'($urandom);
    end else if (pick < 43) begin
      // chosen key pressed along with random keys of lower priority
      keys = matrix_t'($urandom) << k;
      keys[k] = 1'b1;
    end else if (pick < 55) begin
      keys = '0;
      keys[KEY_MODE] = 1'b1;
    end else if (pick < 63) begin
      keys = '0;
      keys[KEY_CAPS] = 1'b1;
    end else begin
      keys = '0;
      keys[k] = 1'b1;
    end
    return keys;
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] MISMATCH: %s", $realtime, what);
    mismatch_count++;
  endtask

  // Offer one snapshot; the expectation is queued at the edge it is taken
  task automatic offer_keys(input matrix_t keys, input bit typed, input dec_res_t typed_res);
    dec_res_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.key_matrix <= keys;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    predicted = predict_keypress(keys);
    pending_codes.push_back(typed ? typed_res : predicted);
    @(negedge clk);
  endtask

  // Receiver: random stalls, plus one long hold-off when the no-idle phase begins
  initial begin
    int  hold_left;
    bit  hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (phase == 2 && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    dec_res_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_codes.size() == 0) begin
        report_mismatch($sformatf("result code %0d with nothing expected", out_ch.key_code));
      end else begin
        want = pending_codes.pop_front();
        if (out_ch.key_code !== want.code)
          report_mismatch($sformatf("key_code %0d, expected %0d", out_ch.key_code, want.code));
        if (out_ch.layer_now !== want.layer)
          report_mismatch($sformatf("layer_now %0d, expected %0d",
                                    out_ch.layer_now, want.layer));
        if (out_ch.caps_on !== want.caps)
          report_mismatch($sformatf("caps_on %0b, expected %0b", out_ch.caps_on, want.caps));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_codes.size());
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    mismatch_count   = 0;
    cycle_count      = 0;
    phase            = 0;
    send_idle_pct    = 6;
    recv_idle_pct    = 71;
    tracked_layer    = '0;
    tracked_caps     = 1'b0;
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.key_matrix <= '0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < $size(KEY_ROWS); i++)
      offer_keys(KEY_ROWS[i].keys, KEY_ROWS[i].typed, KEY_ROWS[i].res);

    for (int p = 0; p < 3; p++) begin
      phase         = p;
      send_idle_pct = (p == 0) ? 6 : (p == 1) ? 71 : 0;
      recv_idle_pct = (p == 0) ? 71 : (p == 1) ? 6 : 0;
      repeat (ITEMS_PER_PHASE) offer_keys(random_keys(), 1'b0, '0);
    end
    in_ch.valid <= 1'b0;

    while (pending_codes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+design
design/kmd_pkg.sv
design/kmd_ifs.sv
design/kmd_prio_enc.sv
design/kmd_decode.sv
design/keypad_matrix_mode_decoder.sv
verif/keypad_matrix_mode_decoder_test.sv
